FILE: rtl/core/gswc_pkg.sv
// ----------------------------------------------------------------------------
// gswc_pkg
// Shared constants, types and helpers of the glyph stroke window composite.
// ----------------------------------------------------------------------------
package gswc_pkg;

   localparam int MaxLine   = 1024;
   localparam int MaxWin    = 7;
   localparam int KeptRows  = MaxWin - 1;
   localparam int PixW      = 32;
   localparam int AddrW     = $clog2(MaxLine);
   localparam int LineW     = KeptRows * PixW;
   localparam int MaskW     = MaxWin * MaxWin;
   localparam int RowLimit  = 4095;

   typedef logic [PixW-1:0]  pix_type;
   typedef logic [LineW-1:0] line_type;
   typedef logic [MaxWin-1:0][MaxWin-1:0][7:0] win_type;

   typedef enum logic [2:0] {
      CSR_LINE_WIDTH   = 3'd0,
      CSR_WINDOW_SIZE  = 3'd1,
      CSR_MASK_BITS    = 3'd2,
      CSR_STROKE_RED   = 3'd3,
      CSR_STROKE_GREEN = 3'd4,
      CSR_STROKE_BLUE  = 3'd5,
      CSR_STROKE_ALPHA = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [2:0]       win;
      logic [MaskW-1:0] mask;
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
      logic [7:0]       alpha;
   } stroke_cfg_type;

   // Exact floor(x / 255) for x up to 65025.
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
      return t[15:8];
   endfunction

   function automatic logic [7:0] sat8(input logic [8:0] x);
      return x[8] ? 8'hff : x[7:0];
   endfunction

endpackage

FILE: rtl/core/gswc_if.sv
// ----------------------------------------------------------------------------
// gswc interfaces
// Pixel, result and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface gswc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pix_red;
   logic [7:0] pix_green;
   logic [7:0] pix_blue;
   logic [7:0] pix_alpha;
   logic       frame_start;
   modport source (output valid, pix_red, pix_green, pix_blue, pix_alpha, frame_start,
                   input ready);
   modport sink   (input valid, pix_red, pix_green, pix_blue, pix_alpha, frame_start,
                   output ready);
endinterface

interface gswc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic [7:0] out_alpha;
   logic       end_of_row;
   modport source (output valid, out_red, out_green, out_blue, out_alpha, end_of_row,
                   input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_alpha, end_of_row,
                   output ready);
endinterface

interface gswc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [48:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/gswc_line_ram.sv
// ----------------------------------------------------------------------------
// gswc_line_ram
// Line buffer memory, one word of kept rows per column, cleared after reset.
// ----------------------------------------------------------------------------
module gswc_line_ram (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    rd_en,
   input  logic [gswc_pkg::AddrW-1:0] rd_addr,
   input  logic                    wr_en,
   input  logic [gswc_pkg::AddrW-1:0] wr_addr,
   input  gswc_pkg::line_type      wr_data,
   output gswc_pkg::line_type      rd_data,
   output logic                    busy
);

   gswc_pkg::line_type mem [gswc_pkg::MaxLine];
   gswc_pkg::line_type rd_data_ff;
   logic                         clear_ff, clear_in;
   logic [gswc_pkg::AddrW-1:0]   clr_addr_ff, clr_addr_in;

   always_comb begin
      clr_addr_in = clr_addr_ff + gswc_pkg::AddrW'(1);
      clear_in    = clear_ff && (clr_addr_ff != gswc_pkg::AddrW'(gswc_pkg::MaxLine - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clear_ff) begin
         clear_ff    <= clear_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clear_ff;

endmodule

FILE: rtl/core/gswc_blend.sv
// ----------------------------------------------------------------------------
// gswc_blend
// Masked window alpha sum, stroke coverage and compositing over seven stages.
// ----------------------------------------------------------------------------
module gswc_blend (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    take,
   input  gswc_pkg::stroke_cfg_type cfg,
   input  gswc_pkg::win_type       win,
   input  gswc_pkg::pix_type       cpix,
   output logic                    done,
   output logic [7:0]              res_red,
   output logic [7:0]              res_green,
   output logic [7:0]              res_blue,
   output logic [7:0]              res_alpha
);

   localparam int Rcp = 66051;   // floor(2^32 / 65025)

   logic [6:0] vld_ff, vld_in;
   logic       done_ff, done_in;

   // Stage A
   logic [gswc_pkg::MaxWin-1:0][10:0] rs_ff, rs_in;
   gswc_pkg::pix_type a_pix_ff, b_pix_ff, c_pix_ff, d_pix_ff, e_pix_ff, f_pix_ff;
   // Stage B
   logic [15:0] cov_p_ff, sr_p_ff, sg_p_ff, sb_p_ff;
   logic [13:0] total;
   logic [7:0]  sat_sum;
   // Stage C
   logic [7:0]  cov_ff, sr_ff, sg_ff, sb_ff, comp_ff;
   // Stage D
   logic [15:0] m_ff, tr_ff, tg_ff, tb_ff;
   logic [7:0]  dr_ff, dg_ff, db_ff, dcov_ff;
   // Stage E
   logic [23:0] pr_ff, pg_ff, pb_ff, er_ff, eg_ff, eb_ff;
   logic [7:0]  oa_ff, tr0_ff, tg0_ff, tb0_ff, ecov_ff;
   // Stage F
   logic [40:0] qr_ff, qg_ff, qb_ff;
   logic [7:0]  foa_ff, ftr_ff, ftg_ff, ftb_ff, fcov_ff;
   // Stage G
   logic [7:0]  g_r_ff, g_g_ff, g_b_ff, g_a_ff, g_r_in, g_g_in, g_b_in, g_a_in;
   logic [7:0]  qr8, qg8, qb8;

   function automatic logic [7:0] q65025(input logic [40:0] prod, input logic [23:0] p);
      logic [8:0]  q;
      logic [25:0] rem;
      q   = prod[40:32];
      rem = {2'b0, p} - 26'(q) * 26'd65025;
      if (rem >= 26'd65025) begin
         q = q + 9'd1;
      end
      return q[7:0];
   endfunction

   always_comb begin
      logic [2:0] wy, wx;
      logic [5:0] bit_idx;
      for (int y = 0; y < gswc_pkg::MaxWin; y++) begin
         rs_in[y] = '0;
         for (int x = 0; x < gswc_pkg::MaxWin; x++) begin
            bit_idx = 6'(y) * 6'(cfg.win) + 6'(x);
            wy = cfg.win - 3'd1 - 3'(y);
            wx = cfg.win - 3'd1 - 3'(x);
            if ((3'(y) < cfg.win) && (3'(x) < cfg.win) && cfg.mask[bit_idx]) begin
               rs_in[y] = rs_in[y] + 11'(win[wy][wx]);
            end
         end
      end
   end

   always_comb begin
      total = '0;
      for (int y = 0; y < gswc_pkg::MaxWin; y++) begin
         total = total + 14'(rs_ff[y]);
      end
      sat_sum = (total > 14'd255) ? 8'hff : total[7:0];
   end

   always_comb begin
      qr8 = q65025(qr_ff, er_ff);
      qg8 = q65025(qg_ff, eg_ff);
      qb8 = q65025(qb_ff, eb_ff);
      if (f_pix_ff[31:24] == 8'hff) begin
         g_r_in = f_pix_ff[7:0];
         g_g_in = f_pix_ff[15:8];
         g_b_in = f_pix_ff[23:16];
         g_a_in = 8'hff;
      end else if (f_pix_ff[31:24] == 8'h00) begin
         g_r_in = ftr_ff;
         g_g_in = ftg_ff;
         g_b_in = ftb_ff;
         g_a_in = fcov_ff;
      end else begin
         g_r_in = gswc_pkg::sat8({1'b0, f_pix_ff[7:0]} + {1'b0, qr8});
         g_g_in = gswc_pkg::sat8({1'b0, f_pix_ff[15:8]} + {1'b0, qg8});
         g_b_in = gswc_pkg::sat8({1'b0, f_pix_ff[23:16]} + {1'b0, qb8});
         g_a_in = foa_ff;
      end
   end

   always_comb begin
      vld_in  = {vld_ff[5:0], start};
      done_in = vld_ff[6] || (done_ff && !take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         vld_ff  <= vld_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      // A: row sums of the masked window
      rs_ff    <= rs_in;
      a_pix_ff <= cpix;
      // B: coverage and stroke premultiply products
      cov_p_ff <= 16'(sat_sum) * 16'(cfg.alpha);
      sr_p_ff  <= 16'(cfg.red) * 16'(cfg.alpha);
      sg_p_ff  <= 16'(cfg.green) * 16'(cfg.alpha);
      sb_p_ff  <= 16'(cfg.blue) * 16'(cfg.alpha);
      b_pix_ff <= a_pix_ff;
      // C: divide by 255
      cov_ff   <= gswc_pkg::div255(cov_p_ff);
      sr_ff    <= gswc_pkg::div255(sr_p_ff);
      sg_ff    <= gswc_pkg::div255(sg_p_ff);
      sb_ff    <= gswc_pkg::div255(sb_p_ff);
      comp_ff  <= 8'hff - b_pix_ff[31:24];
      c_pix_ff <= b_pix_ff;
      // D: blend weight and transparent-centre products
      m_ff     <= 16'(cov_ff) * 16'(comp_ff);
      tr_ff    <= 16'(sr_ff) * 16'(cov_ff);
      tg_ff    <= 16'(sg_ff) * 16'(cov_ff);
      tb_ff    <= 16'(sb_ff) * 16'(cov_ff);
      dr_ff    <= sr_ff;
      dg_ff    <= sg_ff;
      db_ff    <= sb_ff;
      dcov_ff  <= cov_ff;
      d_pix_ff <= c_pix_ff;
      // E: colour times weight
      pr_ff    <= 24'(dr_ff) * 24'(m_ff);
      pg_ff    <= 24'(dg_ff) * 24'(m_ff);
      pb_ff    <= 24'(db_ff) * 24'(m_ff);
      oa_ff    <= gswc_pkg::sat8({1'b0, d_pix_ff[31:24]} + {1'b0, gswc_pkg::div255(m_ff)});
      tr0_ff   <= gswc_pkg::div255(tr_ff);
      tg0_ff   <= gswc_pkg::div255(tg_ff);
      tb0_ff   <= gswc_pkg::div255(tb_ff);
      ecov_ff  <= dcov_ff;
      e_pix_ff <= d_pix_ff;
      // F: reciprocal multiply for the divide by 65025
      qr_ff    <= 41'(pr_ff) * 41'(Rcp);
      qg_ff    <= 41'(pg_ff) * 41'(Rcp);
      qb_ff    <= 41'(pb_ff) * 41'(Rcp);
      er_ff    <= pr_ff;
      eg_ff    <= pg_ff;
      eb_ff    <= pb_ff;
      foa_ff   <= oa_ff;
      ftr_ff   <= tr0_ff;
      ftg_ff   <= tg0_ff;
      ftb_ff   <= tb0_ff;
      fcov_ff  <= ecov_ff;
      f_pix_ff <= e_pix_ff;
      // G: correction and centre case select
      if (vld_ff[6]) begin
         g_r_ff <= g_r_in;
         g_g_ff <= g_g_in;
         g_b_ff <= g_b_in;
         g_a_ff <= g_a_in;
      end
   end

   assign done      = done_ff;
   assign res_red   = g_r_ff;
   assign res_green = g_g_ff;
   assign res_blue  = g_b_ff;
   assign res_alpha = g_a_ff;

endmodule

FILE: rtl/core/glyph_stroke_window_composite_top.sv
// ----------------------------------------------------------------------------
// glyph_stroke_window_composite_top
// Stroke compositing of a glyph frame over a square line-buffered window.
// ----------------------------------------------------------------------------
// An emitting pixel beat passes the line memory read, the window load, the
// seven-stage blend and the output register. A new pixel beat is taken only
// once the last is written back and any result of it is in the output register.
// Reset: synchronous, active high; afterwards the 1024-entry line memory is
// cleared one column a cycle, and no pixel beat is taken until that is done.
// ----------------------------------------------------------------------------
module glyph_stroke_window_composite_top (
   input  logic       clock,
   input  logic       reset,
   gswc_req_if.sink   req_ch,
   gswc_rsp_if.source rsp_ch,
   gswc_csr_if.sink   csr_ch
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_LOAD = 3'b010,
      ST_CALC = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [10:0] line_width_ff;
   logic [2:0]  window_size_ff;
   logic [48:0] mask_bits_ff;
   logic [7:0]  stroke_red_ff, stroke_green_ff, stroke_blue_ff, stroke_alpha_ff;

   // Counters and the pixel under work.
   logic [9:0]  col_ff, col_in;
   logic [11:0] row_ff, row_in;
   logic [9:0]  cur_col_ff;
   gswc_pkg::pix_type pix_ff;
   logic        emit_ff, last_ff;

   // Window registers fed from the line memory.
   gswc_pkg::win_type win_ff;
   gswc_pkg::pix_type centre_ff [gswc_pkg::MaxWin];

   logic        start_ff;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_r_ff, rsp_g_ff, rsp_b_ff, rsp_a_ff;
   logic        rsp_eor_ff, rsp_eor_hold_ff;

   logic        accept, ram_busy, blend_done, take;
   logic [2:0]  win_cl, centre_age;
   logic [10:0] width_cl;
   logic [9:0]  base_col;
   logic [11:0] base_row;
   logic        emit_in, last_in;
   gswc_pkg::line_type ram_rd, ram_wr;
   gswc_pkg::stroke_cfg_type cfg;
   logic [7:0]  b_r, b_g, b_b, b_a;

   // Register writes are taken in any cycle.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= 11'd1024;
         window_size_ff  <= 3'd3;
         mask_bits_ff    <= '0;
         stroke_red_ff   <= '0;
         stroke_green_ff <= '0;
         stroke_blue_ff  <= '0;
         stroke_alpha_ff <= 8'hff;
      end else if (csr_ch.valid) begin
         case (gswc_pkg::csr_index_type'(csr_ch.index))
            gswc_pkg::CSR_LINE_WIDTH:   line_width_ff   <= csr_ch.data[10:0];
            gswc_pkg::CSR_WINDOW_SIZE:  window_size_ff  <= csr_ch.data[2:0];
            gswc_pkg::CSR_MASK_BITS:    mask_bits_ff    <= csr_ch.data;
            gswc_pkg::CSR_STROKE_RED:   stroke_red_ff   <= csr_ch.data[7:0];
            gswc_pkg::CSR_STROKE_GREEN: stroke_green_ff <= csr_ch.data[7:0];
            gswc_pkg::CSR_STROKE_BLUE:  stroke_blue_ff  <= csr_ch.data[7:0];
            gswc_pkg::CSR_STROKE_ALPHA: stroke_alpha_ff <= csr_ch.data[7:0];
            default: begin
            end
         endcase
      end
   end

   // Window size zero behaves as one; the line width is held to 1..MaxLine.
   // The centre sits at window index win/2, which is win-1-win/2 columns
   // and rows behind the newest pixel.
   always_comb begin
      win_cl     = (window_size_ff == 3'd0) ? 3'd1 : window_size_ff;
      centre_age = win_cl - 3'd1 - (win_cl >> 1);
      if (line_width_ff == 11'd0) begin
         width_cl = 11'd1;
      end else if (line_width_ff > 11'(gswc_pkg::MaxLine)) begin
         width_cl = 11'(gswc_pkg::MaxLine);
      end else begin
         width_cl = line_width_ff;
      end
   end

   // A frame start beat restarts both counters before it is placed. The
   // row ends at the first column that reaches the width, and the row
   // counter sticks at its limit until the next frame.
   always_comb begin
      base_col = req_ch.frame_start ? 10'd0 : col_ff;
      base_row = req_ch.frame_start ? 12'd0 : row_ff;
      emit_in  = (base_row >= 12'(win_cl - 3'd1)) && (base_col >= 10'(win_cl - 3'd1));
      last_in  = (11'(base_col) + 11'd1) >= width_cl;
      if (last_in) begin
         col_in = 10'd0;
         row_in = (base_row < 12'(gswc_pkg::RowLimit)) ? base_row + 12'd1 : base_row;
      end else begin
         col_in = base_col + 10'd1;
         row_in = base_row;
      end
   end

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && !ram_busy;

   // The memory word for a column holds the kept rows, newest row lowest.
   // The write back shifts them up by one row and puts the new pixel first.
   assign ram_wr = {ram_rd[gswc_pkg::LineW-gswc_pkg::PixW-1:0], pix_ff};

   gswc_line_ram u_line_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (base_col),
      .wr_en   (state_ff == ST_LOAD),
      .wr_addr (cur_col_ff),
      .wr_data (ram_wr),
      .rd_data (ram_rd),
      .busy    (ram_busy)
   );

   // The result register is free once its beat has gone or goes now.
   assign take = (state_ff == ST_CALC) && blend_done && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = emit_ff ? ST_CALC : ST_IDLE;
         end
         ST_CALC: begin
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= (state_ff == ST_LOAD) && emit_ff;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff     <= {req_ch.pix_alpha, req_ch.pix_blue, req_ch.pix_green, req_ch.pix_red};
         cur_col_ff <= base_col;
         emit_ff    <= emit_in;
         last_ff    <= last_in;
      end
      if (state_ff == ST_LOAD) begin
         rsp_eor_hold_ff <= last_ff;
      end
   end

   // Window and centre shift registers advance once per pixel, when the
   // memory word of its column has arrived.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
         for (int j = 0; j < gswc_pkg::MaxWin; j++) begin
            centre_ff[j] <= '0;
         end
      end else if (state_ff == ST_LOAD) begin
         for (int k = 0; k < gswc_pkg::MaxWin; k++) begin
            for (int j = gswc_pkg::MaxWin - 1; j > 0; j--) begin
               win_ff[k][j] <= win_ff[k][j-1];
            end
         end
         win_ff[0][0] <= pix_ff[31:24];
         for (int k = 1; k < gswc_pkg::MaxWin; k++) begin
            win_ff[k][0] <= ram_rd[(k-1)*gswc_pkg::PixW+24 +: 8];
         end
         for (int j = gswc_pkg::MaxWin - 1; j > 0; j--) begin
            centre_ff[j] <= centre_ff[j-1];
         end
         if (centre_age == 3'd0) begin
            centre_ff[0] <= pix_ff;
         end else begin
            centre_ff[0] <= ram_rd[(int'(centre_age)-1)*gswc_pkg::PixW +: gswc_pkg::PixW];
         end
      end
   end

   always_comb begin
      cfg.win   = win_cl;
      cfg.mask  = mask_bits_ff;
      cfg.red   = stroke_red_ff;
      cfg.green = stroke_green_ff;
      cfg.blue  = stroke_blue_ff;
      cfg.alpha = stroke_alpha_ff;
   end

   gswc_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .take      (take),
      .cfg       (cfg),
      .win       (win_ff),
      .cpix      (centre_ff[centre_age]),
      .done      (blend_done),
      .res_red   (b_r),
      .res_green (b_g),
      .res_blue  (b_b),
      .res_alpha (b_a)
   );

   // Output register: holds one result beat while the next pixel is worked.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_r_ff   <= b_r;
         rsp_g_ff   <= b_g;
         rsp_b_ff   <= b_b;
         rsp_a_ff   <= b_a;
         rsp_eor_ff <= rsp_eor_hold_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_red    = rsp_r_ff;
   assign rsp_ch.out_green  = rsp_g_ff;
   assign rsp_ch.out_blue   = rsp_b_ff;
   assign rsp_ch.out_alpha  = rsp_a_ff;
   assign rsp_ch.end_of_row = rsp_eor_ff;

endmodule

FILE: verif/gswc_stroke_checker.sv
// ----------------------------------------------------------------------------
// gswc_stroke_checker
// Watches the register, pixel and result channels of the stroke compositor.
// It keeps its own line buffers and window, predicts each stroked pixel and
// compares every result beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module gswc_stroke_checker
   import gswc_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   gswc_req_if   req_ch,
   gswc_rsp_if   rsp_ch,
   gswc_csr_if   csr_ch,
   output int    failures,
   output int    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       eor;
   } stroked_pix_type;

   logic [10:0] cfg_line_width;
   logic [2:0]  cfg_window;
   logic [48:0] cfg_mask;
   logic [7:0]  cfg_red, cfg_green, cfg_blue, cfg_alpha;

   pix_type     line_mem [MaxLine][KeptRows];
   logic [7:0]  alpha_win [MaxWin][MaxWin];
   pix_type     centre_row [MaxWin];
   int unsigned col_cnt, row_cnt;

   stroked_pix_type stroked_q[$];

   assign pending = stroked_q.size();

   function automatic logic [7:0] clip8(input int unsigned v);
      return (v > 255) ? 8'hff : v[7:0];
   endfunction

   task automatic stroke_pixel(input pix_type pix, input logic fs);
      int unsigned width, w, half, cage, c, sum, cov, sr, sg, sb, ca, comp, m;
      pix_type old [KeptRows];
      pix_type cpix;
      logic emit, last;
      stroked_pix_type res;
      width = cfg_line_width;
      if (width < 1) width = 1;
      if (width > MaxLine) width = MaxLine;
      w = cfg_window;
      if (w < 1) w = 1;
      half = w / 2;
      cage = w - 1 - half;
      if (fs) begin
         col_cnt = 0;
         row_cnt = 0;
      end
      c = (col_cnt >= MaxLine) ? MaxLine - 1 : col_cnt;
      for (int k = 0; k < KeptRows; k++) old[k] = line_mem[c][k];
      for (int k = 0; k < MaxWin; k++)
         for (int j = MaxWin - 1; j > 0; j--) alpha_win[k][j] = alpha_win[k][j-1];
      for (int j = MaxWin - 1; j > 0; j--) centre_row[j] = centre_row[j-1];
      alpha_win[0][0] = pix[31:24];
      for (int k = 1; k < MaxWin; k++) alpha_win[k][0] = old[k-1][31:24];
      centre_row[0] = (cage == 0) ? pix : old[cage-1];
      for (int k = KeptRows - 1; k > 0; k--) line_mem[c][k] = old[k-1];
      line_mem[c][0] = pix;

      emit = (row_cnt >= w - 1) && (col_cnt >= w - 1);
      last = (col_cnt + 1 >= width);
      if (last) begin
         col_cnt = 0;
         if (row_cnt < RowLimit) row_cnt++;
      end else begin
         col_cnt++;
      end
      if (!emit) return;

      sum = 0;
      for (int y = 0; y < w; y++)
         for (int x = 0; x < w; x++)
            if (cfg_mask[y*w + x]) sum += alpha_win[w-1-y][w-1-x];
      if (sum > 255) sum = 255;
      cov = sum * cfg_alpha / 255;
      sr  = cfg_red * cfg_alpha / 255;
      sg  = cfg_green * cfg_alpha / 255;
      sb  = cfg_blue * cfg_alpha / 255;
      cpix = centre_row[cage];
      ca = cpix[31:24];
      if (ca == 255) begin
         res.red = cpix[7:0]; res.green = cpix[15:8]; res.blue = cpix[23:16];
         res.alpha = 8'd255;
      end else if (ca == 0) begin
         res.red = 8'(sr * cov / 255); res.green = 8'(sg * cov / 255);
         res.blue = 8'(sb * cov / 255); res.alpha = 8'(cov);
      end else begin
         comp = 255 - ca;
         m = cov * comp;
         res.alpha = clip8(ca + m / 255);
         res.red   = clip8(cpix[7:0] + sr * m / 65025);
         res.green = clip8(cpix[15:8] + sg * m / 65025);
         res.blue  = clip8(cpix[23:16] + sb * m / 65025);
      end
      res.eor = last;
      stroked_q.push_back(res);
   endtask

   always @(posedge clock) begin
      stroked_pix_type got, exp_pix;
      if (reset) begin
         cfg_line_width = 11'd1024;
         cfg_window = 3'd3;
         cfg_mask = '0;
         cfg_red = '0; cfg_green = '0; cfg_blue = '0; cfg_alpha = 8'd255;
         foreach (line_mem[i, k]) line_mem[i][k] = '0;
         foreach (alpha_win[i, k]) alpha_win[i][k] = '0;
         foreach (centre_row[i]) centre_row[i] = '0;
         col_cnt = 0;
         row_cnt = 0;
         stroked_q.delete();
         failures = 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_index_type'(csr_ch.index))
               CSR_LINE_WIDTH:   cfg_line_width = csr_ch.data[10:0];
               CSR_WINDOW_SIZE:  cfg_window = csr_ch.data[2:0];
               CSR_MASK_BITS:    cfg_mask = csr_ch.data;
               CSR_STROKE_RED:   cfg_red = csr_ch.data[7:0];
               CSR_STROKE_GREEN: cfg_green = csr_ch.data[7:0];
               CSR_STROKE_BLUE:  cfg_blue = csr_ch.data[7:0];
               CSR_STROKE_ALPHA: cfg_alpha = csr_ch.data[7:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            stroke_pixel({req_ch.pix_alpha, req_ch.pix_blue, req_ch.pix_green,
                          req_ch.pix_red}, req_ch.frame_start);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.out_red, rsp_ch.out_green, rsp_ch.out_blue,
                    rsp_ch.out_alpha, rsp_ch.end_of_row};
            if (stroked_q.size() == 0) begin
               failures++;
               $display("%t: unexpected result beat, actual %h", $realtime, got);
            end else begin
               exp_pix = stroked_q.pop_front();
               if (got !== exp_pix) begin
                  failures++;
                  $display("%t: result r/g/b/a/eor expected %h %h %h %h %b, actual %h %h %h %h %b",
                           $realtime, exp_pix.red, exp_pix.green, exp_pix.blue,
                           exp_pix.alpha, exp_pix.eor, got.red, got.green, got.blue,
                           got.alpha, got.eor);
               end
            end
         end
      end
   end

endmodule

FILE: verif/glyph_stroke_window_composite_top_tb.sv
// ----------------------------------------------------------------------------
// glyph_stroke_window_composite_top_tb
// Drives register settings and glyph pixel frames into the stroke compositor,
// with random idling on both sides, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module glyph_stroke_window_composite_top_tb;
   import gswc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // The watchdog limit covers the line memory clear after reset, the long
   // receiver hold-off and the idle pause before writes.
   localparam int StallLimit = 5000;
   localparam int HoldCycles = 300;

   logic clock;
   logic reset;
   int   failures;
   int   pending;
   bit   calm;        // No idling on either side when set.
   bit   want_hold;   // Asks the receiver for one long hold-off.
   int   quiet_cycles;

   gswc_req_if req_if ();
   gswc_rsp_if rsp_if ();
   gswc_csr_if csr_if ();

   glyph_stroke_window_composite_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   gswc_stroke_checker u_checker (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_if),
      .rsp_ch   (rsp_if),
      .csr_ch   (csr_if),
      .failures (failures),
      .pending  (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The receiver alternates random ready and stall bursts. A long hold-off
   // lets the pipeline fill so that the pixel input has to stall.
   initial begin
      int burst;
      rsp_if.ready = 1'b0;
      forever begin
         if (want_hold) begin
            want_hold = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end else begin
            burst = $urandom_range(1, 15);
            rsp_if.ready <= calm || $urandom_range(0, 1);
            repeat (burst) @(posedge clock);
         end
      end
   end

   // Any cycle in which no beat moves on any channel counts toward a stall.
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (csr_if.valid && csr_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= StallLimit) begin
            $display("glyph_stroke_window_composite_top: mismatch");
            $finish;
         end
      end
   end

   // Presents one pixel beat and waits for it to be taken. Valid stays high
   // so back-to-back pixels stream without a bubble, but for random idle gaps.
   task automatic send_pixel(input pix_type pix, input logic fs);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.pix_red     <= pix[7:0];
      req_if.pix_green   <= pix[15:8];
      req_if.pix_blue    <= pix[23:16];
      req_if.pix_alpha   <= pix[31:24];
      req_if.frame_start <= fs;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic drain;
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      // Pixels that produce no result may still be in flight.
      repeat (24) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [48:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [10:0] lw, input logic [2:0] ws,
                            input logic [48:0] mask, input logic [31:0] stroke);
      drain();
      write_reg(CSR_LINE_WIDTH, 49'(lw));
      write_reg(CSR_WINDOW_SIZE, 49'(ws));
      write_reg(CSR_MASK_BITS, mask);
      write_reg(CSR_STROKE_RED, 49'(stroke[7:0]));
      write_reg(CSR_STROKE_GREEN, 49'(stroke[15:8]));
      write_reg(CSR_STROKE_BLUE, 49'(stroke[23:16]));
      write_reg(CSR_STROKE_ALPHA, 49'(stroke[31:24]));
   endtask

   // Glyph-like pixels: mostly clear or opaque, with edge colors and
   // out-of-range colors on partly covered pixels.
   function automatic pix_type glyph_pixel();
      logic [7:0] a;
      logic [23:0] rgb;
      case ($urandom_range(0, 9))
         0, 1, 2: a = 8'd0;
         3, 4, 5: a = 8'd255;
         default: a = 8'($urandom_range(0, 255));
      endcase
      rgb = 24'($urandom);
      if ($urandom_range(0, 7) == 0) rgb = 24'hffffff;
      if ($urandom_range(0, 7) == 0) rgb = 24'h000000;
      return {a, rgb};
   endfunction

   function automatic logic [31:0] stroke_color();
      case ($urandom_range(0, 5))
         0: return 32'hffffffff;
         1: return 32'h00000000;
         2: return {8'hff, 24'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [48:0] mask_pattern();
      case ($urandom_range(0, 5))
         0: return '1;
         1: return '0;
         default: return 49'({$urandom, $urandom});
      endcase
   endfunction

   // A frame of rows x lw pixels; the first pixel may skip frame start so
   // that a row left open by the previous setting carries over.
   task automatic send_frame(input int lw, input int rows, input bit fs_first);
      for (int i = 0; i < lw * rows; i++)
         send_pixel(glyph_pixel(), (i == 0) ? fs_first : ($urandom_range(0, 199) == 0));
   endtask

   initial begin
      pix_type directed [16];
      int lw, ws;
      calm = 1'b0;
      want_hold = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.pix_red = '0;
      req_if.pix_green = '0;
      req_if.pix_blue = '0;
      req_if.pix_alpha = '0;
      req_if.frame_start = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_LINE_WIDTH;
      csr_if.data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a 4x4 frame with a full 3x3 mask and a full stroke. It
      // covers opaque, clear and partly covered centers, and bright colors
      // on low alpha, which must clip at 255.
      configure(11'd4, 3'd3, '1, 32'hffffffff);
      directed = '{32'h00000000, 32'hffffffff, 32'h01ffffff, 32'h80ffffff,
                   32'hff000000, 32'h00ffffff, 32'hfe123456, 32'h7f000000,
                   32'h00000000, 32'h00000000, 32'h40abcdef, 32'hffffffff,
                   32'h01000000, 32'hff808080, 32'h00000000, 32'hc0ffffff};
      foreach (directed[i]) send_pixel(directed[i], i == 0);

      // Zero width and zero window act as one; a clear stroke.
      configure(11'd0, 3'd0, '1, 32'h00ffffff);
      for (int i = 0; i < 3; i++) send_pixel(glyph_pixel(), i == 0);

      // A width beyond the line memory clamps to its size.
      configure(11'd2047, 3'd1, 49'd1, 32'hff80ff01);
      for (int i = 0; i < 4; i++) send_pixel(glyph_pixel(), i == 0);

      // Even window: its center sits at index window_size/2.
      configure(11'd5, 3'd4, mask_pattern(), 32'hff40c0ff);
      send_frame(5, 5, 1'b1);

      // A row left half done, then a narrower width: the row ends at the
      // first column at or past the new width.
      configure(11'd9, 3'd3, '1, 32'hffff0000);
      send_frame(9, 3, 1'b1);
      for (int i = 0; i < 6; i++) send_pixel(glyph_pixel(), 1'b0);
      configure(11'd3, 3'd3, '1, 32'hffff0000);
      send_frame(3, 3, 1'b0);

      // The start of a row at the full line width with the largest window;
      // the open row carries over into the next setting.
      configure(11'd1024, 3'd7, mask_pattern(), stroke_color());
      for (int i = 0; i < 48; i++) send_pixel(glyph_pixel(), i == 0);

      // Random settings and frames. Mid-way the receiver holds off for a
      // long stretch while pixels keep coming, and once the sender stops
      // after a frame until every stroked pixel has come back.
      for (int ph = 0; ph < 12; ph++) begin
         if (ph >= 10) calm = 1'b1;
         lw = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         ws = $urandom_range(0, 7);
         configure(11'(lw), 3'(ws), mask_pattern(), stroke_color());
         if (ph == 6) want_hold = 1'b1;
         for (int f = $urandom_range(1, 2); f > 0; f--) begin
            send_frame(lw, ws + $urandom_range(0, 3), $urandom_range(0, 3) != 0);
            if (ph == 9 && f == 1) begin
               req_if.valid <= 1'b0;
               @(posedge clock);
               while (pending != 0) @(posedge clock);
            end
         end
      end

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (failures == 0)
         $display("glyph_stroke_window_composite_top: match");
      else
         $display("glyph_stroke_window_composite_top: mismatch");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/gswc_pkg.sv
rtl/core/gswc_if.sv
rtl/core/gswc_line_ram.sv
rtl/core/gswc_blend.sv
rtl/core/glyph_stroke_window_composite_top.sv
verif/gswc_stroke_checker.sv
verif/glyph_stroke_window_composite_top_tb.sv
